@@ rtl/core/bmsi_pkg.sv @@
package bmsi_pkg;

    localparam int MOD_W = 9;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CPU   = 2'd2;
    localparam logic [1:0] MODE_VIDEO = 2'd3;

    localparam logic [15:0] DECODE_MASK     = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [15:0] REG_MIRROR      = 16'hA000;
    localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] REG_IRQ_CLEAR   = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

    localparam logic [1:0] CFG_PRG_BANKS   = 2'd0;
    localparam logic [1:0] CFG_CHR_BANKS   = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

    localparam logic [2:0] FIRST_PRG_REG = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] addr;
        logic [7:0]  data;
    } in_item_t;

    typedef struct packed {
        logic        irq_pending;
        logic        horizontal_mirror;
        logic [18:0] prg_rom_offset;
        logic [17:0] chr_rom_offset;
    } out_item_t;

    typedef struct packed {
        logic             go;
        logic [7:0]       value;
        logic [MOD_W-1:0] modulus;
    } mod_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] rem;
    } mod_resp_t;

endpackage

@@ rtl/core/bank_mapper_with_scanline_irq.sv @@
// Bank mapper with scanline interrupt counter.
// Input channel: an item (mode, addr, data) transfers at a clock edge where
// start is high and busy is low. Modes: register write, scanline tick,
// CPU address translation, video address translation.
// Output channel: each item yields one result, shown on result for exactly
// one cycle while done is high. The receiver cannot stall; a result not taken
// in that cycle is lost.
// For every item except a bank-data register write, the result is registered
// at the accepting edge and appears in the cycle after it.
// A bank-data write reduces the byte modulo the ROM bank count in a shared
// restoring remainder unit, one quotient bit per cycle over eight iterations;
// busy stays high until the remainder unit finishes and the result is shown.
// Throughput: one item per cycle, none while a bank-data write is busy.
// Configuration: cfg_we, cfg_index, cfg_data write a register at once; write
// only while the block is idle. Index 0 program banks, 1 character banks,
// 2 four-screen.
// Reset clears all bank, select, mirroring and interrupt state and loads the
// configuration defaults (two program banks, one character bank).
module bank_mapper_with_scanline_irq
    import bmsi_pkg::*;
#(
    parameter int MAX_PRG_BANKS = 32,
    parameter int MAX_CHR_BANKS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_item_t   item,
    output logic       done,
    output out_item_t  result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

    state_t     state_reg;
    state_t     state_next;

    logic [5:0] prg_cfg_reg;
    logic [5:0] chr_cfg_reg;
    logic       four_screen_reg;

    logic [7:0] bank_select_reg;
    logic [7:0] bank_select_next;
    logic [7:0] bank_regs_reg [8];
    logic [7:0] reload_reg;
    logic [7:0] reload_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic       enabled_reg;
    logic       enabled_next;
    logic       irq_flag_reg;
    logic       irq_flag_next;
    logic       mirror_reg;
    logic       mirror_next;
    logic [2:0] idx_reg;

    logic       done_reg;
    logic       done_next;
    out_item_t  result_reg;
    out_item_t  result_next;

    logic       accept;
    logic       go;
    logic [15:0] dec;
    logic [5:0] prg_count;
    logic [5:0] chr_count;
    logic [6:0] second_last;
    logic [5:0] prg_bank;
    logic [2:0] chr_win;
    logic [2:0] chr_idx;
    logic [7:0] chr_reg;
    logic [18:0] prg_off;
    logic [17:0] chr_off;
    mod_req_t   mod_req;
    mod_resp_t  mod_resp;

    assign accept = start && (state_reg == ST_IDLE);
    assign dec    = item.addr & DECODE_MASK;
    assign go     = accept && (item.mode == MODE_WRITE) && (dec == REG_BANK_DATA);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        if (prg_cfg_reg == 6'd0)
        begin
            prg_count = 6'd1;
        end
        else if (prg_cfg_reg > 6'(MAX_PRG_BANKS))
        begin
            prg_count = 6'(MAX_PRG_BANKS);
        end
        else
        begin
            prg_count = prg_cfg_reg;
        end
        if (chr_cfg_reg == 6'd0)
        begin
            chr_count = 6'd1;
        end
        else if (chr_cfg_reg > 6'(MAX_CHR_BANKS))
        begin
            chr_count = 6'(MAX_CHR_BANKS);
        end
        else
        begin
            chr_count = chr_cfg_reg;
        end
    end

    always_comb
    begin
        mod_req.go = go;
        mod_req.value = item.data;
        if (bank_select_reg[2:0] < FIRST_PRG_REG)
        begin
            mod_req.modulus = {chr_count, 3'b000};
        end
        else
        begin
            mod_req.modulus = {2'b00, prg_count, 1'b0};
        end
    end

    bmsi_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .resp  (mod_resp)
    );

    always_comb
    begin
        second_last = {prg_count, 1'b0} - 7'd2;
        case (item.addr[14:13])
            2'd0:
            begin
                prg_bank = bank_select_reg[6] ? second_last[5:0] : bank_regs_reg[6][5:0];
            end
            2'd1:
            begin
                prg_bank = bank_regs_reg[7][5:0];
            end
            2'd2:
            begin
                prg_bank = bank_select_reg[6] ? bank_regs_reg[6][5:0] : second_last[5:0];
            end
            default:
            begin
                prg_bank = second_last[5:0] + 6'd1;
            end
        endcase
        prg_off = {prg_bank, item.addr[12:0]};

        chr_win = item.addr[12:10] ^ {bank_select_reg[7], 2'b00};
        if (!chr_win[2])
        begin
            chr_idx = {2'b00, chr_win[1]};
        end
        else
        begin
            chr_idx = {1'b0, chr_win[1:0]} + 3'd2;
        end
        chr_reg = bank_regs_reg[chr_idx];
        if (!chr_win[2])
        begin
            chr_off = {chr_reg[7:1], chr_win[0], item.addr[9:0]};
        end
        else
        begin
            chr_off = {chr_reg, item.addr[9:0]};
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        bank_select_next = bank_select_reg;
        reload_next      = reload_reg;
        count_next       = count_reg;
        enabled_next     = enabled_reg;
        irq_flag_next    = irq_flag_reg;
        mirror_next      = mirror_reg;
        done_next        = 1'b0;
        result_next      = result_reg;

        if (state_reg == ST_DIV)
        begin
            if (mod_resp.done)
            begin
                state_next = ST_IDLE;
                done_next = 1'b1;
                result_next.irq_pending = irq_flag_reg;
                result_next.horizontal_mirror = mirror_reg;
                result_next.prg_rom_offset = '0;
                result_next.chr_rom_offset = '0;
            end
        end
        else if (accept)
        begin
            result_next.prg_rom_offset = '0;
            result_next.chr_rom_offset = '0;
            case (item.mode)
                MODE_WRITE:
                begin
                    case (dec)
                        REG_BANK_SELECT: bank_select_next = item.data;
                        REG_BANK_DATA:   state_next = ST_DIV;
                        REG_MIRROR:
                        begin
                            if (!four_screen_reg)
                            begin
                                mirror_next = item.data[0];
                            end
                        end
                        REG_IRQ_LATCH:   reload_next = item.data;
                        REG_IRQ_CLEAR:   count_next = '0;
                        REG_IRQ_DISABLE:
                        begin
                            enabled_next = 1'b0;
                            irq_flag_next = 1'b0;
                        end
                        REG_IRQ_ENABLE:  enabled_next = 1'b1;
                        default:         ;
                    endcase
                end
                MODE_TICK:
                begin
                    if (count_reg == 8'd0)
                    begin
                        count_next = reload_reg;
                    end
                    else
                    begin
                        count_next = count_reg - 8'd1;
                    end
                    if ((count_next == 8'd0) && enabled_reg)
                    begin
                        irq_flag_next = 1'b1;
                    end
                end
                MODE_CPU:
                begin
                    result_next.prg_rom_offset = prg_off;
                end
                MODE_VIDEO:
                begin
                    result_next.chr_rom_offset = chr_off;
                end
                default: ;
            endcase
            done_next = !go;
            result_next.irq_pending = irq_flag_next;
            result_next.horizontal_mirror = mirror_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prg_cfg_reg     <= 6'd2;
            chr_cfg_reg     <= 6'd1;
            four_screen_reg <= 1'b0;
            bank_select_reg <= '0;
            reload_reg      <= '0;
            count_reg       <= '0;
            enabled_reg     <= 1'b0;
            irq_flag_reg    <= 1'b0;
            mirror_reg      <= 1'b0;
            done_reg        <= 1'b0;
            idx_reg         <= '0;
            for (int i = 0; i < 8; i++)
            begin
                bank_regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            bank_select_reg <= bank_select_next;
            reload_reg      <= reload_next;
            count_reg       <= count_next;
            enabled_reg     <= enabled_next;
            irq_flag_reg    <= irq_flag_next;
            mirror_reg      <= mirror_next;
            done_reg        <= done_next;
            if (go)
            begin
                idx_reg <= bank_select_reg[2:0];
            end
            if ((state_reg == ST_DIV) && mod_resp.done)
            begin
                bank_regs_reg[idx_reg] <= mod_resp.rem;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRG_BANKS:   prg_cfg_reg <= cfg_data;
                    CFG_CHR_BANKS:   chr_cfg_reg <= cfg_data;
                    CFG_FOUR_SCREEN: four_screen_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_mod_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_resp.done |-> (state_reg == ST_DIV))
        else $error("remainder unit finished outside a bank-data transfer");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(accept && !go) || $past((state_reg == ST_DIV) && mod_resp.done)))
        else $error("result strobe without a completed transfer");

    a_irq_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_flag_reg) |-> $past(accept && (item.mode == MODE_TICK)))
        else $error("interrupt raised without a scanline tick");

    a_go_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> (state_reg == ST_DIV))
        else $error("bank-data write did not enter the remainder sequence");

endmodule

@@ rtl/core/bmsi_mod_unit.sv @@
module bmsi_mod_unit
    import bmsi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mod_req_t  req,
    output mod_resp_t resp
);

    logic             busy_reg;
    logic             done_reg;
    logic [2:0]       cnt_reg;
    logic [7:0]       div_reg;
    logic [7:0]       rem_reg;
    logic [MOD_W-1:0] mod_reg;
    logic [8:0]       trial;
    logic [7:0]       rem_next;

    always_comb
    begin
        trial = {rem_reg, div_reg[7]};
        if (trial >= mod_reg)
        begin
            rem_next = 8'(trial - mod_reg);
        end
        else
        begin
            rem_next = trial[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'd7);
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            div_reg <= req.value;
            rem_reg <= '0;
            mod_reg <= req.modulus;
        end
        else if (busy_reg)
        begin
            div_reg <= {div_reg[6:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign resp.done = done_reg;
    assign resp.rem  = rem_reg;

endmodule

@@ dv/tb_bank_mapper_with_scanline_irq.sv @@
`timescale 1ns / 1ps

module tb_bank_mapper_with_scanline_irq;
    import bmsi_pkg::*;

    localparam int PRG_MAX     = 32;
    localparam int CHR_MAX     = 32;
    localparam int QUIET_LIMIT = 4000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    in_item_t   item = '0;
    logic       done;
    out_item_t  result;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_PRG_BANKS;
    logic [5:0] cfg_data = '0;

    in_item_t   pending[$];
    out_item_t  results_due[$];
    int         idle_pct = 36;
    int         n_rand = 0;
    int         quiet = 0;
    bit         failed = 1'b0;

    logic [5:0] prg_banks_q = 6'd2;
    logic [5:0] chr_banks_q = 6'd1;
    logic       four_q = 1'b0;
    logic [7:0] sel_q = '0;
    logic [7:0] bank_q [8];
    logic [7:0] latch_q = '0;
    logic [7:0] count_q = '0;
    logic       irq_en_q = 1'b0;
    logic       irq_q = 1'b0;
    logic       mirror_q = 1'b0;

    bank_mapper_with_scanline_irq u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic out_item_t map_item(in_item_t it);
        out_item_t r;
        int        prg_n;
        int        chr_n;
        int        bank;
        int        last2;
        int        win;
        int        off;
        logic [12:0] low;
        r = '0;
        prg_n = (prg_banks_q == 0) ? 1 : (prg_banks_q > PRG_MAX) ? PRG_MAX : int'(prg_banks_q);
        chr_n = (chr_banks_q == 0) ? 1 : (chr_banks_q > CHR_MAX) ? CHR_MAX : int'(chr_banks_q);
        case (it.mode)
            MODE_WRITE:
            begin
                case (it.addr & DECODE_MASK)
                    REG_BANK_SELECT: sel_q = it.data;
                    REG_BANK_DATA:
                    begin
                        if (sel_q[2:0] < FIRST_PRG_REG)
                            bank_q[sel_q[2:0]] = 8'(int'(it.data) % (8 * chr_n));
                        else
                            bank_q[sel_q[2:0]] = 8'(int'(it.data) % (2 * prg_n));
                    end
                    REG_MIRROR:
                    begin
                        if (!four_q)
                            mirror_q = it.data[0];
                    end
                    REG_IRQ_LATCH:   latch_q = it.data;
                    REG_IRQ_CLEAR:   count_q = '0;
                    REG_IRQ_DISABLE:
                    begin
                        irq_en_q = 1'b0;
                        irq_q = 1'b0;
                    end
                    REG_IRQ_ENABLE:  irq_en_q = 1'b1;
                    default: ;
                endcase
            end
            MODE_TICK:
            begin
                if (count_q == 0)
                    count_q = latch_q;
                else
                    count_q = count_q - 8'd1;
                if (count_q == 0 && irq_en_q)
                    irq_q = 1'b1;
            end
            MODE_CPU:
            begin
                last2 = 2 * prg_n - 2;
                case (it.addr[14:13])
                    2'd0: bank = sel_q[6] ? last2 : int'(bank_q[6]);
                    2'd1: bank = int'(bank_q[7]);
                    2'd2: bank = sel_q[6] ? int'(bank_q[6]) : last2;
                    default: bank = last2 + 1;
                endcase
                off = bank * 'h2000 + int'(it.addr[12:0]);
                r.prg_rom_offset = off[18:0];
            end
            default:
            begin
                low = it.addr[12:0];
                win = int'(low[12:10]) ^ (sel_q[7] ? 4 : 0);
                if (win < 4)
                    off = int'(bank_q[win[1]] >> 1) * 'h800 + (win[0] ? 'h400 : 0);
                else
                    off = int'(bank_q[win[1:0] + 2]) * 'h400;
                off = off + int'(low[9:0]);
                r.chr_rom_offset = off[17:0];
            end
        endcase
        r.irq_pending = irq_q;
        r.horizontal_mirror = mirror_q;
        return r;
    endfunction

    task automatic check_field(string what, logic [18:0] want, logic [18:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            failed = 1'b1;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (start && !busy)
                void'(pending.pop_front());
            if (!(start && busy))
            begin
                if (pending.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    item <= pending[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor and predictor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            prg_banks_q = 6'd2;
            chr_banks_q = 6'd1;
            four_q = 1'b0;
            sel_q = '0;
            for (int i = 0; i < 8; i++)
                bank_q[i] = '0;
            latch_q = '0;
            count_q = '0;
            irq_en_q = 1'b0;
            irq_q = 1'b0;
            mirror_q = 1'b0;
            results_due.delete();
        end
        else
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result expected none got %h", $time, result);
                    failed = 1'b1;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("irq_pending", want.irq_pending, result.irq_pending);
                    check_field("horizontal_mirror", want.horizontal_mirror,
                                result.horizontal_mirror);
                    check_field("prg_rom_offset", want.prg_rom_offset, result.prg_rom_offset);
                    check_field("chr_rom_offset", want.chr_rom_offset, result.chr_rom_offset);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRG_BANKS:   prg_banks_q = cfg_data;
                    CFG_CHR_BANKS:   chr_banks_q = cfg_data;
                    CFG_FOUR_SCREEN: four_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                results_due.push_back(map_item(item));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(logic [1:0] m, logic [15:0] a, logic [7:0] d);
        in_item_t it;
        while (pending.size() >= 4)
            @(negedge clk);
        it.mode = m;
        it.addr = a;
        it.data = d;
        pending.push_back(it);
        idle_pct = (n_rand < 550) ? 36 : (n_rand < 1100) ? 81 : 0;
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || start || results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [5:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic set_config(int prg, int chr, int four);
        wait_drained();
        repeat (12) @(negedge clk);
        cfg_write(CFG_PRG_BANKS, 6'(prg));
        cfg_write(CFG_CHR_BANKS, 6'(chr));
        cfg_write(CFG_FOUR_SCREEN, 6'(four));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] reg_code(int k);
        case (k)
            0: return REG_BANK_SELECT;
            1: return REG_BANK_DATA;
            2: return REG_MIRROR;
            3: return REG_IRQ_LATCH;
            4: return REG_IRQ_CLEAR;
            5: return REG_IRQ_DISABLE;
            default: return REG_IRQ_ENABLE;
        endcase
    endfunction

    function automatic logic [15:0] reg_addr(logic [15:0] code);
        return (16'($urandom) & ~DECODE_MASK) | code;
    endfunction

    task automatic run_random(int n);
        int          stop;
        int          r;
        int          k;
        logic [15:0] a;
        logic [7:0]  d;
        stop = n_rand + n;
        while (n_rand < stop)
        begin
            r = $urandom_range(99);
            if (r < 25)
            begin
                send(MODE_WRITE, reg_addr(REG_BANK_SELECT), 8'($urandom));
                send(MODE_WRITE, reg_addr(REG_BANK_DATA), 8'($urandom));
                n_rand += 2;
            end
            else if (r < 37)
            begin
                d = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(6));
                send(MODE_WRITE, reg_addr(REG_IRQ_LATCH), d);
                send(MODE_WRITE, reg_addr(REG_IRQ_CLEAR), 8'($urandom));
                if ($urandom_range(3) != 0)
                    send(MODE_WRITE, reg_addr(REG_IRQ_ENABLE), 8'($urandom));
                else
                    send(MODE_WRITE, reg_addr(REG_IRQ_DISABLE), 8'($urandom));
                k = $urandom_range(1, 9);
                for (int i = 0; i < k; i++)
                    send(MODE_TICK, 16'($urandom), 8'($urandom));
                n_rand += 3 + k;
            end
            else if (r < 50)
            begin
                send(MODE_TICK, 16'($urandom), 8'($urandom));
                n_rand++;
            end
            else if (r < 65)
            begin
                a = 16'($urandom);
                if ($urandom_range(7) != 0)
                    a[15] = 1'b1;
                send(MODE_CPU, a, 8'($urandom));
                n_rand++;
            end
            else if (r < 80)
            begin
                a = 16'($urandom);
                if ($urandom_range(7) != 0)
                    a[15:13] = 3'd0;
                send(MODE_VIDEO, a, 8'($urandom));
                n_rand++;
            end
            else if (r < 92)
            begin
                send(MODE_WRITE, reg_addr(reg_code($urandom_range(6))), 8'($urandom));
                n_rand++;
            end
            else
            begin
                send(2'($urandom), 16'($urandom), 8'($urandom));
                n_rand++;
            end
            if ($urandom_range(39) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            bank_q[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(MODE_WRITE, REG_BANK_SELECT, 8'h06);
        send(MODE_WRITE, REG_BANK_DATA, 8'hFF);
        send(MODE_WRITE, REG_BANK_SELECT, 8'h47);
        send(MODE_WRITE, REG_BANK_DATA, 8'h80);
        send(MODE_CPU, 16'h8000, 8'h00);
        send(MODE_CPU, 16'hFFFF, 8'hFF);
        send(MODE_CPU, 16'h0000, 8'h00);
        send(MODE_CPU, 16'hC123, 8'h00);
        send(MODE_WRITE, REG_BANK_SELECT, 8'h00);
        send(MODE_WRITE, REG_BANK_DATA, 8'h13);
        send(MODE_WRITE, REG_BANK_SELECT, 8'h85);
        send(MODE_WRITE, REG_BANK_DATA, 8'hFF);
        send(MODE_VIDEO, 16'h0000, 8'h00);
        send(MODE_VIDEO, 16'h1FFF, 8'h00);
        send(MODE_VIDEO, 16'hFFFF, 8'hFF);
        send(MODE_WRITE, REG_MIRROR, 8'h01);
        send(MODE_WRITE, REG_IRQ_LATCH, 8'h02);
        send(MODE_WRITE, REG_IRQ_CLEAR, 8'h00);
        send(MODE_WRITE, REG_IRQ_ENABLE, 8'h00);
        send(MODE_TICK, 16'h0000, 8'h00);
        send(MODE_TICK, 16'hFFFF, 8'hFF);
        send(MODE_TICK, 16'h0000, 8'h00);
        send(MODE_WRITE, REG_IRQ_DISABLE, 8'h00);
        send(MODE_WRITE, 16'h7FFF, 8'hFF);
        send(MODE_TICK, 16'h0000, 8'h00);

        set_config(1, 1, 0);
        run_random(280);
        set_config(32, 32, 1);
        run_random(280);
        set_config(0, 0, 0);
        run_random(270);
        set_config(63, 63, 1);
        run_random(270);
        set_config($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1));
        run_random(280);
        set_config(2, 1, 0);
        run_random(270);

        wait_drained();
        repeat (20) @(negedge clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
